// ===== hw/rtl/sfa_pkg.sv =====
package sfa_pkg;

  // Field widths.
  localparam int FRAME_BITS    = 10;
  localparam int PIXEL_BITS    = 12;
  localparam int CELL_BITS     = PIXEL_BITS + 1;
  localparam int COL_BITS      = FRAME_BITS + 1;
  localparam int RECT_BITS     = FRAME_BITS + PIXEL_BITS + 1;
  localparam int TIME_BITS     = 32;
  localparam int PROD_BITS     = COL_BITS + CELL_BITS;
  localparam int DIV_CNT_BITS  = $clog2(FRAME_BITS + 1);

  // Configuration port.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Reset values of the configuration registers.
  localparam logic [TIME_BITS-1:0] PERIOD_ONE    = TIME_BITS'(32'h0001_0000);
  localparam logic [COL_BITS-1:0]  COLS_DEFAULT  = COL_BITS'(1);
  localparam logic [CELL_BITS-1:0] CELL_DEFAULT  = CELL_BITS'(2);

  // Register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST_FRAME   = 3'd0,
    CFG_LAST_FRAME    = 3'd1,
    CFG_FRAME_PERIOD  = 3'd2,
    CFG_LOOP_ENABLE   = 3'd3,
    CFG_SHEET_COLUMNS = 3'd4,
    CFG_CELL_WIDTH    = 3'd5,
    CFG_CELL_HEIGHT   = 3'd6
  } cfg_reg_t;

  // Request opcodes.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_t;

endpackage

// ===== hw/rtl/sfa_if.sv =====
// Request channel: one tick or set-frame request.
interface sfa_in_if;
  import sfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [TIME_BITS-1:0]  elapsed_time;
  logic [FRAME_BITS-1:0] new_frame;

  modport source (output valid, output opcode, output elapsed_time, output new_frame,
                  input ready);
  modport sink   (input valid, input opcode, input elapsed_time, input new_frame,
                  output ready);
endinterface

// Result channel: current frame and its source rectangle.
interface sfa_out_if;
  import sfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] frame_index;
  logic [RECT_BITS-1:0]  rect_left;
  logic [RECT_BITS-1:0]  rect_top;
  logic [RECT_BITS-1:0]  rect_right;
  logic [RECT_BITS-1:0]  rect_bottom;
  logic                  anim_done;
  logic                  frame_changed;

  modport source (output valid, output frame_index, output rect_left, output rect_top,
                  output rect_right, output rect_bottom, output anim_done,
                  output frame_changed, input ready);
  modport sink   (input valid, input frame_index, input rect_left, input rect_top,
                  input rect_right, input rect_bottom, input anim_done,
                  input frame_changed, output ready);
endinterface

// ===== hw/rtl/sfa_divider.sv =====
module sfa_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sfa_pkg::FRAME_BITS-1:0] dividend,
  input  logic [sfa_pkg::COL_BITS-1:0]   divisor,
  output logic                           done,
  output logic [sfa_pkg::FRAME_BITS-1:0] quotient,
  output logic [sfa_pkg::COL_BITS-1:0]   remainder
);
  import sfa_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [FRAME_BITS-1:0]   quo_r;
  logic [COL_BITS-1:0]     rem_r;
  logic [COL_BITS-1:0]     div_r;

  logic [COL_BITS:0]       trial;
  logic [COL_BITS+1:0]     diff;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial = {rem_r, quo_r[FRAME_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, div_r};

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_BITS'(FRAME_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient and partial remainder, one bit a cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      if (!diff[COL_BITS+1]) begin
        rem_r <= diff[COL_BITS-1:0];
      end else begin
        rem_r <= trial[COL_BITS-1:0];
      end
      quo_r <= {quo_r[FRAME_BITS-2:0], ~diff[COL_BITS+1]};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hw/rtl/sprite_frame_animator_core.sv =====
// A request passes through the states accumulate, advance, divider start, divider
// wait, left multiply, top multiply, finish and output; the wait on the
// bit-serial row/column divider is the longest of these steps.
// The block takes no new request until the pending result has been taken.
// Reset (synchronous, rst_n low) restores the register defaults and clears
// the frame, the time accumulator and the done flag.
module sprite_frame_animator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  sfa_in_if.sink                            in_ch,
  sfa_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [sfa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sfa_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import sfa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_ADV,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_L,
    ST_MUL_T,
    ST_FIN,
    ST_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [FRAME_BITS-1:0] first_r;
  logic [FRAME_BITS-1:0] last_r;
  logic [TIME_BITS-1:0]  period_r;
  logic                  loop_r;
  logic [COL_BITS-1:0]   cols_r;
  logic [CELL_BITS-1:0]  cw_r;
  logic [CELL_BITS-1:0]  ch_r;

  // Animation state.
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [TIME_BITS-1:0]  acc_r, acc_nxt;
  logic                  done_flag_r, done_flag_nxt;
  logic                  changed_r, changed_nxt;
  logic                  out_valid_r;

  // Captured request.
  logic                  op_r;
  logic [TIME_BITS-1:0]  elapsed_r;
  logic [FRAME_BITS-1:0] new_frame_r;

  // Rectangle.
  logic [RECT_BITS-1:0]  left_r, top_r, right_r, bottom_r;

  logic                  in_fire;
  logic                  out_fire;
  logic                  range_ok;
  logic [TIME_BITS:0]    sum;
  logic [TIME_BITS:0]    diff;
  logic                  acc_gt;
  logic [FRAME_BITS:0]   step_frame;
  logic                  out_of_range;
  logic [COL_BITS-1:0]   cols_eff;

  logic                  div_done;
  logic [FRAME_BITS-1:0] div_quo;
  logic [COL_BITS-1:0]   div_rem;

  logic [COL_BITS-1:0]   mul_a;
  logic [CELL_BITS-1:0]  mul_b;
  logic [PROD_BITS-1:0]  mul_p;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Accumulator add with saturation, and the compare against the period.
  assign range_ok = (last_r > first_r);
  assign sum      = {1'b0, acc_r} + {1'b0, elapsed_r};
  assign diff     = {1'b0, acc_r} - {1'b0, period_r};
  assign acc_gt   = !diff[TIME_BITS] && (diff[TIME_BITS-1:0] != '0);

  // The advanced frame is one bit wider so that stepping past the top index counts as out of range.
  assign step_frame   = {1'b0, frame_r} + (FRAME_BITS+1)'(1);
  assign out_of_range = (step_frame < {1'b0, first_r}) || (step_frame > {1'b0, last_r});

  assign cols_eff = (cols_r == '0) ? COL_BITS'(1) : cols_r;

  // Next values of the animation state.
  always_comb begin
    frame_nxt     = frame_r;
    acc_nxt       = acc_r;
    done_flag_nxt = done_flag_r;
    changed_nxt   = changed_r;
    case (state_r)
      ST_ACC: begin
        changed_nxt = 1'b0;
        if (op_r == OP_SET) begin
          frame_nxt     = new_frame_r;
          done_flag_nxt = 1'b0;
          changed_nxt   = 1'b1;
        end else if (range_ok) begin
          acc_nxt = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        end
      end
      ST_ADV: begin
        if ((op_r == OP_TICK) && range_ok && acc_gt) begin
          acc_nxt     = diff[TIME_BITS-1:0];
          changed_nxt = 1'b1;
          if (!out_of_range) begin
            frame_nxt = step_frame[FRAME_BITS-1:0];
          end else if (loop_r) begin
            frame_nxt = first_r;
          end else begin
            frame_nxt     = last_r;
            done_flag_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Shared multiplier: column times width, then row times height.
  assign mul_a = (state_r == ST_MUL_T) ? {1'b0, div_quo} : div_rem;
  assign mul_b = (state_r == ST_MUL_T) ? ch_r : cw_r;
  assign mul_p = {{CELL_BITS{1'b0}}, mul_a} * {{COL_BITS{1'b0}}, mul_b};

  sfa_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == ST_DIV_GO),
    .dividend  (frame_r),
    .divisor   (cols_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer, animation state, configuration and the result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      frame_r     <= '0;
      acc_r       <= '0;
      done_flag_r <= 1'b0;
      changed_r   <= 1'b0;
      first_r     <= '0;
      last_r      <= '0;
      period_r    <= PERIOD_ONE;
      loop_r      <= 1'b1;
      cols_r      <= COLS_DEFAULT;
      cw_r        <= CELL_DEFAULT;
      ch_r        <= CELL_DEFAULT;
    end else begin
      frame_r     <= frame_nxt;
      acc_r       <= acc_nxt;
      done_flag_r <= done_flag_nxt;
      changed_r   <= changed_nxt;

      unique case (state_r)
        ST_IDLE:     if (in_fire) state_r <= ST_ACC;
        ST_ACC:      state_r <= ST_ADV;
        ST_ADV:      state_r <= ST_DIV_GO;
        ST_DIV_GO:   state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: if (div_done) state_r <= ST_MUL_L;
        ST_MUL_L:    state_r <= ST_MUL_T;
        ST_MUL_T:    state_r <= ST_FIN;
        ST_FIN: begin
          state_r     <= ST_OUT;
          out_valid_r <= 1'b1;
        end
        ST_OUT: begin
          if (out_fire) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        default:     state_r <= ST_IDLE;
      endcase

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_FIRST_FRAME:   first_r  <= cfg_data[FRAME_BITS-1:0];
          CFG_LAST_FRAME:    last_r   <= cfg_data[FRAME_BITS-1:0];
          CFG_FRAME_PERIOD:  period_r <= cfg_data[TIME_BITS-1:0];
          CFG_LOOP_ENABLE:   loop_r   <= cfg_data[0];
          CFG_SHEET_COLUMNS: cols_r   <= cfg_data[COL_BITS-1:0];
          CFG_CELL_WIDTH:    cw_r     <= cfg_data[CELL_BITS-1:0];
          CFG_CELL_HEIGHT:   ch_r     <= cfg_data[CELL_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Request capture and rectangle registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= in_ch.opcode;
      elapsed_r   <= in_ch.elapsed_time;
      new_frame_r <= in_ch.new_frame;
    end
    if (state_r == ST_MUL_L) begin
      left_r <= mul_p[RECT_BITS-1:0];
    end
    if (state_r == ST_MUL_T) begin
      top_r   <= mul_p[RECT_BITS-1:0];
      right_r <= left_r + RECT_BITS'(cw_r);
    end
    if (state_r == ST_FIN) begin
      bottom_r <= top_r + RECT_BITS'(ch_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_index   = frame_r;
  assign out_ch.rect_left     = left_r;
  assign out_ch.rect_top      = top_r;
  assign out_ch.rect_right    = right_r;
  assign out_ch.rect_bottom   = bottom_r;
  assign out_ch.anim_done     = done_flag_r;
  assign out_ch.frame_changed = changed_r;

  // A new request is never taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("request accepted while a result is pending");

  // After a request is taken the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("block ready right after accepting a request");

  // The divider only completes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_WAIT))
    else $error("divider completion outside the wait state");

  // The last arithmetic step is followed by a valid result.
  a_fin_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> out_ch.valid)
    else $error("result not presented after the final step");

endmodule

// ===== bench/sprite_frame_animator_core_tb.sv =====
`timescale 1ns / 1ps

module sprite_frame_animator_core_tb;
  import sfa_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  // One result as the block reports it.
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_index;
    logic [RECT_BITS-1:0]  rect_left;
    logic [RECT_BITS-1:0]  rect_top;
    logic [RECT_BITS-1:0]  rect_right;
    logic [RECT_BITS-1:0]  rect_bottom;
    logic                  anim_done;
    logic                  frame_changed;
  } sprite_result_t;

  // Tracks the animation state and the registers, and holds the results still owed.
  class frame_scoreboard;
    logic [FRAME_BITS-1:0] first_frame;
    logic [FRAME_BITS-1:0] last_frame;
    logic [TIME_BITS-1:0]  frame_period;
    logic                  loop_on;
    logic [COL_BITS-1:0]   columns;
    logic [CELL_BITS-1:0]  cell_w;
    logic [CELL_BITS-1:0]  cell_h;
    logic [FRAME_BITS-1:0] frame;
    logic [TIME_BITS-1:0]  time_acc;
    logic                  done;
    sprite_result_t        owed_q[$];
    int                    fail_count;

    function new();
      first_frame  = '0;
      last_frame   = '0;
      frame_period = PERIOD_ONE;
      loop_on      = 1'b1;
      columns      = COLS_DEFAULT;
      cell_w       = CELL_DEFAULT;
      cell_h       = CELL_DEFAULT;
      frame        = '0;
      time_acc     = '0;
      done         = 1'b0;
      fail_count   = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        CFG_FIRST_FRAME:   first_frame  = value[FRAME_BITS-1:0];
        CFG_LAST_FRAME:    last_frame   = value[FRAME_BITS-1:0];
        CFG_FRAME_PERIOD:  frame_period = value[TIME_BITS-1:0];
        CFG_LOOP_ENABLE:   loop_on      = value[0];
        CFG_SHEET_COLUMNS: columns      = value[COL_BITS-1:0];
        CFG_CELL_WIDTH:    cell_w       = value[CELL_BITS-1:0];
        CFG_CELL_HEIGHT:   cell_h       = value[CELL_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Advance the animation for one accepted request and queue its result.
    function void note_request(opcode_t op, logic [TIME_BITS-1:0] elapsed,
                               logic [FRAME_BITS-1:0] loaded);
      logic [TIME_BITS:0]    sum;
      logic [FRAME_BITS:0]   next;
      logic [COL_BITS-1:0]   cols;
      logic [31:0]           col, row, left, top, right, bottom;
      logic                  changed;
      sprite_result_t        r;
      changed = 1'b0;
      if (op == OP_SET) begin
        frame   = loaded;
        done    = 1'b0;
        changed = 1'b1;
      end else if (last_frame > first_frame) begin
        sum      = {1'b0, time_acc} + {1'b0, elapsed};
        time_acc = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        if (time_acc > frame_period) begin
          next     = {1'b0, frame} + 1'b1;
          time_acc = time_acc - frame_period;
          // Leaving the range either way wraps or stops at the end.
          if (next < {1'b0, first_frame} || next > {1'b0, last_frame}) begin
            if (loop_on) begin
              next = {1'b0, first_frame};
            end else begin
              next = {1'b0, last_frame};
              done = 1'b1;
            end
          end
          frame   = next[FRAME_BITS-1:0];
          changed = 1'b1;
        end
      end
      // Source rectangle; zero columns divides as one.
      cols   = (columns == '0) ? COL_BITS'(1) : columns;
      col    = 32'(frame) % 32'(cols);
      row    = 32'(frame) / 32'(cols);
      left   = col * 32'(cell_w);
      top    = row * 32'(cell_h);
      right  = left + 32'(cell_w);
      bottom = top + 32'(cell_h);
      r.frame_index   = frame;
      r.rect_left     = left[RECT_BITS-1:0];
      r.rect_top      = top[RECT_BITS-1:0];
      r.rect_right    = right[RECT_BITS-1:0];
      r.rect_bottom   = bottom[RECT_BITS-1:0];
      r.anim_done     = done;
      r.frame_changed = changed;
      owed_q.push_back(r);
    endfunction

    function string show(sprite_result_t r);
      return $sformatf("frame=%0d l=%0d t=%0d r=%0d b=%0d done=%b chg=%b",
                       r.frame_index, r.rect_left, r.rect_top, r.rect_right,
                       r.rect_bottom, r.anim_done, r.frame_changed);
    endfunction

    function void check_result(sprite_result_t got);
      sprite_result_t exp;
      if (owed_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with nothing owed: %s", $realtime, show(got));
        return;
      end
      exp = owed_q.pop_front();
      if (got.frame_index !== exp.frame_index || got.rect_left !== exp.rect_left ||
          got.rect_top !== exp.rect_top || got.rect_right !== exp.rect_right ||
          got.rect_bottom !== exp.rect_bottom || got.anim_done !== exp.anim_done ||
          got.frame_changed !== exp.frame_changed) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                   show(exp), show(got));
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  sfa_in_if  req_ch ();
  sfa_out_if res_ch ();

  sprite_frame_animator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  // Settings in force, used to aim the random requests.
  logic [FRAME_BITS-1:0] cur_first;
  logic [FRAME_BITS-1:0] cur_last;
  logic [TIME_BITS-1:0]  cur_period;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit.
  initial begin
    #20_000_000;
    $display("FAIL sprite_frame_animator_core");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Accepted requests feed the predictor.
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready)
      sb.note_request(opcode_t'(req_ch.opcode), req_ch.elapsed_time, req_ch.new_frame);
  end

  // Accepted results are checked against the oldest expectation.
  always @(posedge clk) begin
    sprite_result_t got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.frame_index   = res_ch.frame_index;
      got.rect_left     = res_ch.rect_left;
      got.rect_top      = res_ch.rect_top;
      got.rect_right    = res_ch.rect_right;
      got.rect_bottom   = res_ch.rect_bottom;
      got.anim_done     = res_ch.anim_done;
      got.frame_changed = res_ch.frame_changed;
      sb.check_result(got);
    end
  end

  // Offer one request after an optional random gap and wait for its handshake.
  task automatic send_request(input opcode_t op, input logic [TIME_BITS-1:0] elapsed,
                              input logic [FRAME_BITS-1:0] loaded);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.elapsed_time <= elapsed;
    req_ch.new_frame    <= loaded;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Write every register; only called while the block is idle.
  task automatic apply_settings(input logic [FRAME_BITS-1:0] first,
                                input logic [FRAME_BITS-1:0] last,
                                input logic [TIME_BITS-1:0] period,
                                input logic loop_on,
                                input logic [COL_BITS-1:0] cols,
                                input logic [CELL_BITS-1:0] cw,
                                input logic [CELL_BITS-1:0] ch);
    write_reg(CFG_FIRST_FRAME, 32'(first));
    write_reg(CFG_LAST_FRAME, 32'(last));
    write_reg(CFG_FRAME_PERIOD, period);
    write_reg(CFG_LOOP_ENABLE, 32'(loop_on));
    write_reg(CFG_SHEET_COLUMNS, 32'(cols));
    write_reg(CFG_CELL_WIDTH, 32'(cw));
    write_reg(CFG_CELL_HEIGHT, 32'(ch));
    cfg_we <= 1'b0;
    cur_first  = first;
    cur_last   = last;
    cur_period = period;
  endtask

  function automatic logic [CELL_BITS-1:0] pick_cell();
    case ($urandom_range(9))
      0: return '0;
      1: return CELL_BITS'(4096);
      2: return '1;
      3: return CELL_BITS'($urandom);
      default: return CELL_BITS'($urandom_range(64, 1));
    endcase
  endfunction

  // Mostly short, live ranges with periods that the ticks can reach.
  task automatic apply_random_settings();
    int first, last;
    logic [TIME_BITS-1:0] period;
    logic [COL_BITS-1:0] cols;
    case ($urandom_range(9))
      0, 1: first = 0;
      2: first = 1023 - $urandom_range(8);
      default: first = $urandom_range(1023);
    endcase
    case ($urandom_range(9))
      0: last = $urandom_range(1023);
      1: last = ($urandom_range(1) != 0) ? first : 1023;
      default: last = first + $urandom_range(12, 1);
    endcase
    if (last > 1023) last = 1023;
    case ($urandom_range(9))
      0: period = '0;
      1: period = '1;
      2: period = $urandom;
      default: period = $urandom_range(1 << 18, 1);
    endcase
    case ($urandom_range(9))
      0: cols = '0;
      1: cols = COL_BITS'(1024);
      2: cols = '1;
      3: cols = COL_BITS'($urandom);
      default: cols = COL_BITS'($urandom_range(40, 1));
    endcase
    apply_settings(FRAME_BITS'(first), FRAME_BITS'(last), period,
                   logic'($urandom_range(1)), cols, pick_cell(), pick_cell());
  endtask

  function automatic logic [TIME_BITS-1:0] pick_elapsed();
    int unsigned sel;
    logic [TIME_BITS:0] span;
    sel = $urandom_range(99);
    span = {1'b0, cur_period} << 1;
    if (sel < 10) return '0;
    if (sel < 15) return '1;
    if (sel < 30 || span > {1'b0, 32'hFFFF_FFFF}) return $urandom;
    if (sel < 40) return cur_period + $urandom_range(1);
    if (span == '0) return $urandom_range(3);
    return $urandom_range(span[TIME_BITS-1:0]);
  endfunction

  // Frames near the range, so that below-range and past-end steps happen often.
  function automatic logic [FRAME_BITS-1:0] pick_frame();
    int lo, hi;
    if ($urandom_range(1) == 0) return FRAME_BITS'($urandom);
    lo = int'(cur_first) - 2;
    hi = int'(cur_last) + 2;
    if (lo < 0) lo = 0;
    if (hi > 1023) hi = 1023;
    if (hi < lo) hi = lo;
    return FRAME_BITS'($urandom_range(hi, lo));
  endfunction

  task automatic run_random(input int count);
    opcode_t op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(99) < 12) ? OP_SET : OP_TICK;
      send_request(op, pick_elapsed(), pick_frame());
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_FIRST_FRAME;
    cfg_data       <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_TICK;
    req_ch.elapsed_time <= '0;
    req_ch.new_frame    <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    cur_first      = '0;
    cur_last       = '0;
    cur_period     = PERIOD_ONE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: empty range, so ticks change nothing.
    send_request(OP_TICK, '1, '0);
    send_request(OP_SET, '1, '1);
    send_request(OP_TICK, '0, '0);
    send_request(OP_SET, '0, '0);
    wait_drained();

    // Zero period, zero columns: frames below the range and past the top index wrap.
    apply_settings(10'd2, 10'd5, '0, 1'b1, '0, CELL_BITS'(4096), CELL_BITS'(4096));
    send_request(OP_TICK, '0, '0);
    send_request(OP_TICK, 32'd1, '0);
    send_request(OP_TICK, 32'h8000_0000, '0);
    send_request(OP_SET, '0, '1);
    send_request(OP_TICK, 32'd1, '0);
    send_request(OP_SET, '0, '0);
    send_request(OP_TICK, 32'd5, '1);
    wait_drained();

    // Largest period: the accumulator saturates without advancing.
    apply_settings('0, '1, '1, 1'b0, '1, '1, '0);
    send_request(OP_TICK, '1, '0);
    send_request(OP_TICK, '1, '0);
    wait_drained();

    // One below the largest period: the saturated total advances; stop at the end.
    apply_settings('0, '1, 32'hFFFF_FFFE, 1'b0, COL_BITS'(1024), '0, '1);
    send_request(OP_TICK, '0, '0);
    send_request(OP_SET, '0, '1);
    send_request(OP_TICK, '1, '0);
    send_request(OP_TICK, '1, '0);
    wait_drained();

    // Register writes keep the done flag; a set-frame clears it.
    apply_settings(10'd7, 10'd3, 32'd1, 1'b1, COL_BITS'(1), CELL_BITS'(1), CELL_BITS'(1));
    send_request(OP_TICK, '1, '0);
    send_request(OP_SET, '0, 10'd300);
    wait_drained();

    // Non-looping run at the top of the frame space.
    apply_settings(10'd1020, '1, 32'd100, 1'b0, COL_BITS'(1), CELL_BITS'(5), CELL_BITS'(5));
    send_request(OP_SET, '0, 10'd1022);
    send_request(OP_TICK, 32'd101, '0);
    send_request(OP_TICK, 32'd200, '0);
    send_request(OP_TICK, 32'd50, '0);
    send_request(OP_SET, '0, '1);
    wait_drained();

    // Random phases cycle through the idling patterns; each phase applies several settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        wait_drained();
        apply_random_settings();
        // A long receiver hold-off while requests keep coming.
        if (phase == 0 && blk == 1) hold_req = 1'b1;
        run_random(46);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("PASS sprite_frame_animator_core");
    end else begin
      $display("FAIL sprite_frame_animator_core");
    end
    $finish;
  end

endmodule
